@@ rtl/oldq_pkg.sv @@
`default_nettype none

package oldq_pkg;

    // List size and derived widths
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    // Request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_REMOVE     = 3'd4;
    localparam logic [2:0] REQ_QUERY      = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed_value;
        logic                     found;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/oldq_ram.sv @@
`default_nettype none

module oldq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/oldq_unit.sv @@
`default_nettype none

// Shared address and compare unit: maps a list position onto the ring
// buffer and compares the word coming back from the RAM with the key.
module oldq_unit (
    input  wire logic [oldq_pkg::ADDR_W-1:0] head,
    input  wire logic [oldq_pkg::ADDR_W-1:0] offset,
    input  wire logic [oldq_pkg::DATA_W-1:0] key,
    input  wire logic [oldq_pkg::DATA_W-1:0] rdata,
    output logic      [oldq_pkg::ADDR_W-1:0] addr,
    output logic                             match
);

    localparam int AW = oldq_pkg::ADDR_W;

    logic [AW:0] sum;

    // head + offset, wrapped once around the ring
    always_comb
    begin
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (AW+1)'(oldq_pkg::CAPACITY))
        begin
            sum = sum - (AW+1)'(oldq_pkg::CAPACITY);
        end
        addr = sum[AW-1:0];
    end

    assign match = (rdata == key);

endmodule

`default_nettype wire

@@ rtl/ordered_list_deque_with_search_core.sv @@
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values kept as a ring buffer
// in one single-port-read RAM, walked by a small sequencer with one shared
// address/compare unit. One request at a time: req_stall is high from the
// transfer of a request until its response is loaded into the output
// register. A push that fits writes one RAM word, a pop does one RAM read, a
// query scans entries up to and including the match (or all of them when
// none matches), and a remove by value scans the same way and then closes
// the gap, one entry per cycle through the RAM read and write ports. The
// next request is taken while the previous response still waits in the
// output register.
module ordered_list_deque_with_search_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire oldq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output oldq_pkg::rsp_t     rsp
);

    localparam int AW  = oldq_pkg::ADDR_W;
    localparam int CW  = oldq_pkg::CNT_W;
    localparam int DW  = oldq_pkg::DATA_W;
    localparam int CAP = oldq_pkg::CAPACITY;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_POP   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [AW-1:0]  wdst_reg, wdst_next;
    logic           pend_reg, pend_next;
    logic [2:0]     op_reg, op_next;
    logic [DW-1:0]  val_reg, val_next;
    logic [1:0]     status_reg, status_next;
    logic [DW-1:0]  removed_reg, removed_next;
    logic           found_reg, found_next;
    oldq_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    logic [AW-1:0]  unit_addr;
    logic           unit_match;
    logic [AW-1:0]  head_dec;
    logic [AW-1:0]  head_inc;
    logic           is_full;
    logic           is_empty;
    logic           issue;

    logic           rd_en;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [DW-1:0]  wr_data;
    logic [DW-1:0]  rd_data;

    oldq_unit u_unit (
        .head   (head_reg),
        .offset (idx_reg[AW-1:0]),
        .key    (val_reg),
        .rdata  (rd_data),
        .addr   (unit_addr),
        .match  (unit_match)
    );

    oldq_ram #(
        .WIDTH (DW),
        .DEPTH (CAP)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (unit_addr),
        .rd_data (rd_data)
    );

    // Ring pointer helpers
    assign head_dec = (head_reg == '0) ? AW'(CAP - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(CAP - 1)) ? '0 : head_reg + AW'(1);
    assign is_full  = (count_reg == CW'(CAP));
    assign is_empty = (count_reg == '0);
    assign issue    = (idx_reg < count_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        addr_next      = addr_reg;
        wdst_next      = wdst_reg;
        pend_next      = pend_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = unit_addr;
        wr_data        = val_reg;

        // response register drains on transfer
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.req_type;
                    val_next     = req.item_value;
                    status_next  = oldq_pkg::ST_OK;
                    removed_next = '0;
                    found_next   = 1'b0;
                    pend_next    = 1'b0;
                    if (req.req_type == oldq_pkg::REQ_POP_BACK)
                    begin
                        idx_next = count_reg - CW'(1);
                    end
                    else if (req.req_type == oldq_pkg::REQ_PUSH_BACK)
                    begin
                        idx_next = count_reg;
                    end
                    else
                    begin
                        idx_next = '0;
                    end
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    oldq_pkg::REQ_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = oldq_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    oldq_pkg::REQ_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = oldq_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    oldq_pkg::REQ_POP_FRONT, oldq_pkg::REQ_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = oldq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = S_POP;
                        end
                    end
                    oldq_pkg::REQ_REMOVE:
                    begin
                        if (is_empty)
                        begin
                            status_next = oldq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    oldq_pkg::REQ_QUERY:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // capture the popped word
            S_POP:
            begin
                removed_next = rd_data;
                if (op_reg == oldq_pkg::REQ_POP_FRONT)
                begin
                    head_next = head_inc;
                end
                count_next = count_reg - CW'(1);
                state_next = S_DONE;
            end

            // read one entry per cycle, compare the one read last cycle
            S_SCAN:
            begin
                if (pend_reg && unit_match)
                begin
                    found_next = 1'b1;
                    pend_next  = 1'b0;
                    if (op_reg == oldq_pkg::REQ_QUERY)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    pend_next = issue;
                    if (issue)
                    begin
                        rd_en     = 1'b1;
                        addr_next = unit_addr;
                        idx_next  = idx_reg + CW'(1);
                    end
                    else
                    begin
                        // last entry compared without a match, or list empty
                        status_next = oldq_pkg::ST_NOTFOUND;
                        state_next  = S_DONE;
                    end
                end
            end

            // close the gap: read entry k+1, write it one slot down
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wdst_reg;
                    wr_data = rd_data;
                end
                pend_next = issue;
                if (issue)
                begin
                    rd_en     = 1'b1;
                    addr_next = unit_addr;
                    wdst_next = addr_reg;
                    idx_next  = idx_reg + CW'(1);
                end
                else
                begin
                    // final move (if any) is written this cycle
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            // hand the response to the output register
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.removed_value = removed_reg;
                    rsp_next.found         = found_reg;
                    rsp_next.occupancy     = oldq_pkg::OCC_W'(count_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        addr_reg    <= addr_next;
        wdst_reg    <= wdst_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        rsp_reg     <= rsp_next;
    end

endmodule

`default_nettype wire

@@ rtl/oldq_checker.sv @@
`default_nettype none

module oldq_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire oldq_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire oldq_pkg::rsp_t rsp
);

    // Occupancy never exceeds the list size
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.occupancy <= oldq_pkg::OCC_W'(oldq_pkg::CAPACITY)))
        else $error("occupancy above capacity");

    // A full refusal only happens with the list at capacity
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == oldq_pkg::ST_FULL)
        |-> (rsp.occupancy == oldq_pkg::OCC_W'(oldq_pkg::CAPACITY)))
        else $error("full status with room left");

    // An empty report only happens on an empty list
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == oldq_pkg::ST_EMPTY) |-> (rsp.occupancy == '0))
        else $error("empty status with entries held");

    // A match is always reported with an ok status and no popped word
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.found)
        |-> (rsp.status == oldq_pkg::ST_OK && rsp.removed_value == '0))
        else $error("found flag with bad status or popped word");

    // One request at a time: busy right after a request transfer
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while previous one in progress");

endmodule

bind ordered_list_deque_with_search_core oldq_checker u_oldq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

@@ tb/sv/ordered_list_deque_with_search_core_tb.sv @@
`timescale 1ns / 100ps

module ordered_list_deque_with_search_core_tb;

    // Request codes the block does not decode; they must be ignored
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_mode_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    oldq_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    oldq_pkg::rsp_t rsp;

    // Shadow copy of the list, front at index 0
    logic signed [oldq_pkg::DATA_W-1:0] list_shadow[$];
    // Responses still owed by the block, oldest first
    oldq_pkg::rsp_t                     awaited_rsp[$];

    int          fail_count = 0;
    int          burst_left = 0;
    int          gap_max = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          hold_off_req = 0;
    int          hold_left = 0;
    int          stall_run = 0;
    int          pattern_phase = 0;

    ordered_list_deque_with_search_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("[ordered_list_deque_with_search_core] ERROR");
        $finish;
    end

    // Index of the frontmost entry equal to v, -1 when absent
    function automatic int find_first(input logic signed [oldq_pkg::DATA_W-1:0] v);
        for (int i = 0; i < list_shadow.size(); i++)
        begin
            if (list_shadow[i] == v)
                return i;
        end
        return -1;
    endfunction

    // Apply one request to the shadow list and return the response it owes
    function automatic oldq_pkg::rsp_t apply_request(input oldq_pkg::req_t r);
        oldq_pkg::rsp_t o;
        int             pos;
        o = '0;
        case (r.req_type)
            oldq_pkg::REQ_PUSH_FRONT:
                if (list_shadow.size() >= oldq_pkg::CAPACITY)
                    o.status = oldq_pkg::ST_FULL;
                else
                    list_shadow.push_front(r.item_value);
            oldq_pkg::REQ_PUSH_BACK:
                if (list_shadow.size() >= oldq_pkg::CAPACITY)
                    o.status = oldq_pkg::ST_FULL;
                else
                    list_shadow.push_back(r.item_value);
            oldq_pkg::REQ_POP_FRONT:
                if (list_shadow.size() == 0)
                    o.status = oldq_pkg::ST_EMPTY;
                else
                    o.removed_value = list_shadow.pop_front();
            oldq_pkg::REQ_POP_BACK:
                if (list_shadow.size() == 0)
                    o.status = oldq_pkg::ST_EMPTY;
                else
                    o.removed_value = list_shadow.pop_back();
            oldq_pkg::REQ_REMOVE:
                if (list_shadow.size() == 0)
                    o.status = oldq_pkg::ST_EMPTY;
                else
                begin
                    pos = find_first(r.item_value);
                    if (pos >= 0)
                    begin
                        o.found = 1'b1;
                        list_shadow.delete(pos);
                    end
                    else
                        o.status = oldq_pkg::ST_NOTFOUND;
                end
            oldq_pkg::REQ_QUERY:
            begin
                pos = find_first(r.item_value);
                if (pos >= 0)
                    o.found = 1'b1;
                else
                    o.status = oldq_pkg::ST_NOTFOUND;
            end
            default:
                ;
        endcase
        o.occupancy = oldq_pkg::OCC_W'(list_shadow.size());
        return o;
    endfunction

    function automatic oldq_pkg::req_t make_req(input logic [2:0] t,
                                                input logic signed [oldq_pkg::DATA_W-1:0] v);
        oldq_pkg::req_t r;
        r.req_type   = t;
        r.item_value = v;
        return r;
    endfunction

    // Value mix: mostly hits and small duplicates, some full-range and extremes
    function automatic logic signed [oldq_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40 && list_shadow.size() > 0)
            return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
        else if (sel < 70)
            return $signed($urandom_range(0, 8)) - 4;
        else if (sel < 90)
            return $signed($urandom);
        else
            case ($urandom_range(0, 3))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return -1;
                default: return 0;
            endcase
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%t %s", $realtime, msg);
    endtask

    // Send one request in bursts with random gaps; predict on transfer
    task automatic send_req(input oldq_pkg::req_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        awaited_rsp.push_back(apply_request(item));
    endtask

    // Response side stall generator, with a long hold-off on request
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            pattern_phase++;
            if (hold_off_req > 0)
            begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                case (stall_mode)
                    STALL_RANDOM:
                        rsp_stall <= ($urandom_range(0, 2) == 0);
                    STALL_PATTERN:
                        rsp_stall <= ((pattern_phase % 7) >= 4);
                    STALL_HEAVY:
                    begin
                        if (stall_run == 0 && $urandom_range(0, 7) == 0)
                            stall_run = $urandom_range(5, 25);
                        rsp_stall <= (stall_run > 0);
                        if (stall_run > 0)
                            stall_run--;
                    end
                    default:
                        rsp_stall <= 1'b0;
                endcase
        end
    end

    // Compare every response transfer with the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        oldq_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp.size() == 0)
                report_failure($sformatf(
                    "unexpected response status=%0d removed=%0d found=%0b occ=%0d",
                    rsp.status, rsp.removed_value, rsp.found, rsp.occupancy));
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status ||
                    rsp.removed_value !== want.removed_value ||
                    rsp.found !== want.found || rsp.occupancy !== want.occupancy)
                    report_failure($sformatf({
                        "mismatch: want status=%0d removed=%0d found=%0b occ=%0d, ",
                        "got status=%0d removed=%0d found=%0b occ=%0d"},
                        want.status, want.removed_value, want.found, want.occupancy,
                        rsp.status, rsp.removed_value, rsp.found, rsp.occupancy));
            end
        end
    end

    // Empty-list refusals, extremes, duplicates, hits and misses, spare codes
    task automatic test_directed();
        gap_max    = 0;
        stall_mode = STALL_NONE;
        send_req(make_req(oldq_pkg::REQ_POP_FRONT, 32'sh7FFFFFFF));
        send_req(make_req(oldq_pkg::REQ_POP_BACK, 32'sh80000000));
        send_req(make_req(oldq_pkg::REQ_REMOVE, 0));
        send_req(make_req(oldq_pkg::REQ_QUERY, 0));
        send_req(make_req(REQ_SPARE_6, -1));
        send_req(make_req(REQ_SPARE_7, 32'sh7FFFFFFF));
        send_req(make_req(oldq_pkg::REQ_PUSH_FRONT, 32'sh7FFFFFFF));
        send_req(make_req(oldq_pkg::REQ_PUSH_BACK, 32'sh80000000));
        send_req(make_req(oldq_pkg::REQ_PUSH_BACK, 0));
        send_req(make_req(oldq_pkg::REQ_PUSH_FRONT, -1));
        send_req(make_req(oldq_pkg::REQ_PUSH_BACK, 5));
        send_req(make_req(oldq_pkg::REQ_PUSH_FRONT, 5));
        send_req(make_req(oldq_pkg::REQ_QUERY, 5));
        send_req(make_req(oldq_pkg::REQ_QUERY, 123));
        // duplicate 5: only the frontmost goes
        send_req(make_req(oldq_pkg::REQ_REMOVE, 5));
        send_req(make_req(oldq_pkg::REQ_QUERY, 5));
        send_req(make_req(oldq_pkg::REQ_REMOVE, 99));
        send_req(make_req(REQ_SPARE_7, 0));
        send_req(make_req(oldq_pkg::REQ_POP_FRONT, 0));
        send_req(make_req(oldq_pkg::REQ_POP_BACK, 0));
        send_req(make_req(oldq_pkg::REQ_QUERY, 32'sh80000000));
        send_req(make_req(oldq_pkg::REQ_REMOVE, 32'sh80000000));
    endtask

    // Fill past capacity, search and remove inside, then drain past empty
    task automatic test_fill_and_drain(input stall_mode_t mode, input int gaps);
        stall_mode = mode;
        gap_max    = gaps;
        while (list_shadow.size() < oldq_pkg::CAPACITY)
            send_req(make_req($urandom_range(0, 1) ? oldq_pkg::REQ_PUSH_BACK
                                                   : oldq_pkg::REQ_PUSH_FRONT,
                              pick_value()));
        repeat (2)
            send_req(make_req($urandom_range(0, 1) ? oldq_pkg::REQ_PUSH_BACK
                                                   : oldq_pkg::REQ_PUSH_FRONT,
                              $signed($urandom)));
        repeat (4)
            send_req(make_req(oldq_pkg::REQ_QUERY, pick_value()));
        // last entry scanned on a full list
        send_req(make_req(oldq_pkg::REQ_REMOVE, list_shadow[oldq_pkg::CAPACITY - 1]));
        repeat (5)
            send_req(make_req($urandom_range(0, 1) ? oldq_pkg::REQ_REMOVE
                                                   : oldq_pkg::REQ_QUERY,
                              pick_value()));
        while (list_shadow.size() > 0)
            send_req(make_req($urandom_range(0, 1) ? oldq_pkg::REQ_POP_BACK
                                                   : oldq_pkg::REQ_POP_FRONT,
                              $signed($urandom)));
        send_req(make_req(oldq_pkg::REQ_POP_FRONT, $signed($urandom)));
        send_req(make_req(oldq_pkg::REQ_REMOVE, pick_value()));
    endtask

    // Weighted random traffic; spare codes are sent but not counted
    task automatic test_random_mix(input int count, input int push_pct, input int pop_pct,
                                   input stall_mode_t mode, input int gaps);
        int             done;
        int             sel;
        oldq_pkg::req_t r;
        done       = 0;
        stall_mode = mode;
        gap_max    = gaps;
        while (done < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 2)
                r.req_type = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;
            else if (sel < 2 + push_pct)
                r.req_type = $urandom_range(0, 1) ? oldq_pkg::REQ_PUSH_BACK
                                                  : oldq_pkg::REQ_PUSH_FRONT;
            else if (sel < 2 + push_pct + pop_pct)
                r.req_type = $urandom_range(0, 1) ? oldq_pkg::REQ_POP_BACK
                                                  : oldq_pkg::REQ_POP_FRONT;
            else
                r.req_type = $urandom_range(0, 1) ? oldq_pkg::REQ_QUERY
                                                  : oldq_pkg::REQ_REMOVE;
            r.item_value = pick_value();
            send_req(r);
            if (r.req_type != REQ_SPARE_6 && r.req_type != REQ_SPARE_7)
                done++;
        end
    endtask

    // Long response hold-off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        stall_mode   = STALL_NONE;
        gap_max      = 0;
        hold_off_req = 400;
        repeat (40)
            send_req(make_req(3'($urandom_range(0, 5)), pick_value()));
    endtask

    // Main sequence
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain(STALL_RANDOM, 4);
        test_random_mix(350, 55, 15, STALL_RANDOM, 4);
        test_random_mix(350, 20, 50, STALL_PATTERN, 0);
        test_output_backpressure();
        test_random_mix(350, 35, 30, STALL_NONE, 0);
        test_random_mix(350, 25, 15, STALL_HEAVY, 8);
        test_fill_and_drain(STALL_HEAVY, 0);
        test_random_mix(150, 45, 25, STALL_PATTERN, 6);

        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (fail_count == 0)
            $display("[ordered_list_deque_with_search_core] OK");
        else
            $display("[ordered_list_deque_with_search_core] ERROR");
        $finish;
    end

endmodule
